// File: hw/rtl/sec2date_pkg.sv
// Shared widths, bounds and reciprocal constants for the seconds to date/hour converter.
package sec2date_pkg;

	// Port widths
	localparam int unsigned SECS_W   = 39;
	localparam int unsigned YEAR_W   = 14;
	localparam int unsigned MONTH_W  = 4;
	localparam int unsigned DAY_W    = 5;
	localparam int unsigned HOUR_W   = 5;
	localparam int unsigned PACKED_W = 34;

	// Input clamp: 0000-01-01T00 .. 9999-12-31T23:59:59
	localparam logic signed [SECS_W-1:0] SECS_LOW  = -39'sd62167219200;
	localparam logic signed [SECS_W-1:0] SECS_HIGH = 39'sd253402300799;

	// 24 * (719468 + 146097): makes the hour count non-negative, day count shifted
	localparam logic [26:0] HOUR_OFS = 27'd20773560;

	// Reciprocals: m = ceil(2^k / d), k = bits(x) + clog2(d), exact for all x
	localparam int unsigned DIV225_HI_K = 25;   // x < 2^17
	localparam logic [17:0] DIV225_HI_M =
		18'(((64'd1 << DIV225_HI_K) + 64'd224) / 64'd225);
	localparam int unsigned DIV225_LO_K = 33;   // x < 2^25
	localparam logic [25:0] DIV225_LO_M =
		26'(((64'd1 << DIV225_LO_K) + 64'd224) / 64'd225);
	localparam int unsigned DIV3_K = 26;        // x < 2^24
	localparam logic [24:0] DIV3_M =
		25'(((64'd1 << DIV3_K) + 64'd2) / 64'd3);
	localparam int unsigned DIV_ERA_K = 40;     // x < 2^22, d = 146097
	localparam logic [22:0] DIV_ERA_M =
		23'(((64'd1 << DIV_ERA_K) + 64'd146096) / 64'd146097);
	localparam int unsigned DIV1460_K = 29;     // x < 2^18
	localparam logic [18:0] DIV1460_M =
		19'(((64'd1 << DIV1460_K) + 64'd1459) / 64'd1460);
	localparam int unsigned DIV365_K = 27;      // x < 2^18
	localparam logic [18:0] DIV365_M =
		19'(((64'd1 << DIV365_K) + 64'd364) / 64'd365);
	localparam int unsigned DIV100_K = 16;      // x < 2^9
	localparam logic [9:0] DIV100_M =
		10'(((64'd1 << DIV100_K) + 64'd99) / 64'd100);
	localparam int unsigned DIV153_K = 19;      // x < 2^11
	localparam logic [11:0] DIV153_M =
		12'(((64'd1 << DIV153_K) + 64'd152) / 64'd153);

	// Day of year at which month index mp (March = 0) starts: (153*mp + 2) / 5
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

// File: hw/rtl/seconds_to_calendar_date_hour.sv
// Pipelined conversion of signed epoch seconds to Gregorian year, month, day and hour.
//
// Converts a signed count of whole seconds since 1970-01-01T00 into the proleptic
// Gregorian year, month, day and hour, plus a packed decimal yyyymmddhh word.
// A word is taken at every clock edge where start is high (busy is always low:
// the 18-stage pipeline accepts one word per cycle, every cycle). Each result
// appears at stage s18, held for one cycle and flagged by
// done; results leave in input order and the receiver has no way to stall them.
// Inputs outside 0000-01-01T00 .. 9999-12-31T23:59:59 are clamped to the nearest
// bound. Seconds are divided by 3600 truncating toward zero, so the hour either
// side of the epoch both read as 1970-01-01 hour 0; the hour/day split then
// rounds toward minus infinity. Leap seconds are ignored. A computed year 0 is
// reported as 1970 (month, day and hour kept). Every constant division other than
// by a power of two is a multiply by a reciprocal, each in a stage of its own.
module seconds_to_calendar_date_hour (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      start,
	output logic                                      busy,
	input  logic signed [sec2date_pkg::SECS_W-1:0]    epoch_seconds,
	output logic                                      done,
	output logic [sec2date_pkg::YEAR_W-1:0]           year,
	output logic [sec2date_pkg::MONTH_W-1:0]          month,
	output logic [sec2date_pkg::DAY_W-1:0]            day,
	output logic [sec2date_pkg::HOUR_W-1:0]           hour,
	output logic [sec2date_pkg::PACKED_W-1:0]         packed_date_hour
);
	import sec2date_pkg::*;

	localparam int unsigned LATENCY = 18;

	// valid bit per stage, bit i = stage i+1
	logic [LATENCY-1:0] vld_q;

	// stage registers
	logic        neg_s1, neg_s2, neg_s3, neg_s4;
	logic [33:0] n_s1, n_s2;
	logic [9:0]  qh_s2, qh_s3;
	logic [24:0] x_s3;
	logic [26:0] q_s4;
	logic [26:0] hrs_s5;
	logic [21:0] z_s6, z_s7;
	logic [4:0]  hlo_s6;
	logic [4:0]  era_s7, era_s8, era_s9, era_s10, era_s11, era_s12, era_s13, era_s14;
	logic [4:0]  hh_s7, hh_s8, hh_s9, hh_s10, hh_s11, hh_s12, hh_s13, hh_s14, hh_s15;
	logic [4:0]  hh_s16, hh_s17, hh_s18;
	logic [17:0] doe_s8, doe_s9, doe_s10, doe_s11, doe_s12;
	logic [6:0]  a_s9;
	logic [2:0]  b_s9;
	logic        c_s9;
	logic [17:0] t_s10;
	logic [8:0]  yoe_s11, yoe_s12, yoe_s13, yoe_s14;
	logic [1:0]  c100_s12;
	logic [17:0] y365_s12;
	logic [8:0]  doy_s13, doy_s14;
	logic [3:0]  mp_s14;
	logic [3:0]  mon_s15, mon_s16, mon_s17, mon_s18;
	logic [4:0]  day_s15, day_s16, day_s17, day_s18;
	logic [13:0] ysum_s15;
	logic [13:0] year_s16, year_s17, year_s18;
	logic [33:0] yprod_s17;
	logic [16:0] rest_s17;
	logic [33:0] packed_s18;

	// combinational
	logic signed [SECS_W-1:0] sat;
	logic [SECS_W-1:0]        mag;
	logic [34:0]              prod_a;
	logic [16:0]              rh_full;
	logic [50:0]              prod_b;
	logic [48:0]              prod_c;
	logic [44:0]              prod_d;
	logic [4:0]               hh_c;
	logic [21:0]              doe_full;
	logic [36:0]              prod_e;
	logic [2:0]               b_c;
	logic [36:0]              prod_f;
	logic [18:0]              prod_g;
	logic [17:0]              doy_full;
	logic [10:0]              x5;
	logic [22:0]              prod_h;
	logic [8:0]               day_full;
	logic [3:0]               mon_c;
	logic [13:0]              ysum_c;

	always_comb begin
		// clamp, then magnitude / 16 (3600 = 16 * 225)
		if (epoch_seconds < SECS_LOW) begin
			sat = SECS_LOW;
		end else if (epoch_seconds > SECS_HIGH) begin
			sat = SECS_HIGH;
		end else begin
			sat = epoch_seconds;
		end
		mag = sat[SECS_W-1] ? SECS_W'(-sat) : SECS_W'(sat);

		// /225 in two halves: high 17 bits, then remainder:low 17 bits
		prod_a  = n_s1[33:17] * DIV225_HI_M;
		rh_full = 17'(n_s2[33:17] - 17'(qh_s2 * 17'd225));
		prod_b  = x_s3 * DIV225_LO_M;

		// days = hours / 24 = (hours / 8) / 3; hour of day from low bits
		prod_c  = hrs_s5[26:3] * DIV3_M;
		hh_c    = 5'(hlo_s6 - 5'(z_s6[1:0] * 5'd24));

		// 400-year era and day of era
		prod_d   = z_s6 * DIV_ERA_M;
		doe_full = 22'(z_s7 - 22'(era_s7 * 22'd146097));

		// year of era
		prod_e = doe_s8 * DIV1460_M;
		b_c    = 3'(doe_s8 >= 18'd36524) + 3'(doe_s8 >= 18'd73048) +
		         3'(doe_s8 >= 18'd109572) + 3'(doe_s8 >= 18'd146096);
		prod_f = t_s10 * DIV365_M;
		prod_g = yoe_s11 * DIV100_M;

		// day of year, then March-based month
		doy_full = 18'(doe_s12 - (y365_s12 + 18'(yoe_s12[8:2]) - 18'(c100_s12)));
		x5       = 11'({doy_s13, 2'b00} + 11'(doy_s13) + 11'd2);
		prod_h   = x5 * DIV153_M;

		day_full = 9'(doy_s14 - month_start(mp_s14) + 9'd1);
		mon_c    = (mp_s14 < 4'd10) ? 4'(mp_s14 + 4'd3) : 4'(mp_s14 - 4'd9);
		// year + 400, always positive
		ysum_c   = 14'(14'(yoe_s14) + 14'(era_s14 * 14'd400) + 14'(mon_c <= 4'd2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LATENCY-2:0], start};
		end
	end

	always_ff @(posedge clk) begin
		// s1
		neg_s1 <= sat[SECS_W-1];
		n_s1   <= mag[37:4];
		// s2
		neg_s2 <= neg_s1;
		n_s2   <= n_s1;
		qh_s2  <= prod_a[34:25];
		// s3
		neg_s3 <= neg_s2;
		qh_s3  <= qh_s2;
		x_s3   <= {rh_full[7:0], n_s2[16:0]};
		// s4
		neg_s4 <= neg_s3;
		q_s4   <= {qh_s3, prod_b[49:33]};
		// s5: shifted hour count, >= 0
		hrs_s5 <= neg_s4 ? 27'(HOUR_OFS - q_s4) : 27'(HOUR_OFS + q_s4);
		// s6
		z_s6   <= prod_c[47:26];
		hlo_s6 <= hrs_s5[4:0];
		// s7
		z_s7   <= z_s6;
		era_s7 <= prod_d[44:40];
		hh_s7  <= hh_c;
		// s8
		doe_s8 <= doe_full[17:0];
		era_s8 <= era_s7;
		hh_s8  <= hh_s7;
		// s9
		doe_s9 <= doe_s8;
		a_s9   <= prod_e[35:29];
		b_s9   <= b_c;
		c_s9   <= (doe_s8 == 18'd146096);
		era_s9 <= era_s8;
		hh_s9  <= hh_s8;
		// s10
		t_s10   <= 18'(doe_s9 - 18'(a_s9) + 18'(b_s9) - 18'(c_s9));
		doe_s10 <= doe_s9;
		era_s10 <= era_s9;
		hh_s10  <= hh_s9;
		// s11
		yoe_s11 <= prod_f[35:27];
		doe_s11 <= doe_s10;
		era_s11 <= era_s10;
		hh_s11  <= hh_s10;
		// s12
		c100_s12 <= prod_g[17:16];
		y365_s12 <= 18'(yoe_s11 * 18'd365);
		yoe_s12  <= yoe_s11;
		doe_s12  <= doe_s11;
		era_s12  <= era_s11;
		hh_s12   <= hh_s11;
		// s13
		doy_s13 <= doy_full[8:0];
		yoe_s13 <= yoe_s12;
		era_s13 <= era_s12;
		hh_s13  <= hh_s12;
		// s14
		mp_s14  <= prod_h[22:19];
		doy_s14 <= doy_s13;
		yoe_s14 <= yoe_s13;
		era_s14 <= era_s13;
		hh_s14  <= hh_s13;
		// s15
		mon_s15  <= mon_c;
		day_s15  <= day_full[4:0];
		ysum_s15 <= ysum_c;
		hh_s15   <= hh_s14;
		// s16: drop the 400 bias; year 0 reads as 1970
		year_s16 <= (ysum_s15 <= 14'd400) ? 14'(ysum_s15 + 14'd1570)
		                                  : 14'(ysum_s15 - 14'd400);
		mon_s16  <= mon_s15;
		day_s16  <= day_s15;
		hh_s16   <= hh_s15;
		// s17
		yprod_s17 <= 34'(year_s16 * 34'd1000000);
		rest_s17  <= 17'(17'(mon_s16 * 17'd10000) + 17'(day_s16 * 17'd100) + 17'(hh_s16));
		year_s17  <= year_s16;
		mon_s17   <= mon_s16;
		day_s17   <= day_s16;
		hh_s17    <= hh_s16;
		// s18
		packed_s18 <= 34'(yprod_s17 + 34'(rest_s17));
		year_s18   <= year_s17;
		mon_s18    <= mon_s17;
		day_s18    <= day_s17;
		hh_s18     <= hh_s17;
	end

	// fully pipelined, never refuses a word
	assign busy             = 1'b0;
	assign done             = vld_q[LATENCY-1];
	assign year             = year_s18;
	assign month            = mon_s18;
	assign day              = day_s18;
	assign hour             = hh_s18;
	assign packed_date_hour = packed_s18;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("result missing after fixed latency");

	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (month >= 4'd1 && month <= 4'd12 && day >= 5'd1 && day <= 5'd31 &&
		          hour <= 5'd23 && year != 14'd0))
		else $error("date field out of range");

	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (packed_date_hour == 34'(34'(year) * 34'd1000000 +
		          34'(month) * 34'd10000 + 34'(day) * 34'd100 + 34'(hour))))
		else $error("packed word disagrees with fields");

	a_era: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[6] |-> (era_s7 <= 5'd25))
		else $error("era beyond clamped range");

endmodule
